FILE: design/assert_macros.svh
// Assertion macros shared by the RTL of the integer to decimal text block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

FILE: design/itda_pkg.sv
// Shared types, constants and the power-of-ten table for the decimal text block.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
package itda_pkg;
	localparam int VALUE_W     = 32;
	localparam int NDIG_W      = 4;
	localparam int POW_W       = 34;
	localparam int DIFF_W      = POW_W + 1;
	localparam int DIGIT_MAX   = 9;
	localparam int MAX_DIGITS  = 10;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] mag;
		logic [NDIG_W-1:0]  ndig;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SIGN  = 3'b010,
		ST_DIGIT = 3'b100
	} back_state_t;

	function automatic logic [POW_W-1:0] pow10(input logic [NDIG_W-1:0] k);
		logic [POW_W-1:0] r;
		case (k)
			4'd0: r = POW_W'(1);
			4'd1: r = POW_W'(10);
			4'd2: r = POW_W'(100);
			4'd3: r = POW_W'(1000);
			4'd4: r = POW_W'(10000);
			4'd5: r = POW_W'(100000);
			4'd6: r = POW_W'(1000000);
			4'd7: r = POW_W'(10000000);
			4'd8: r = POW_W'(100000000);
			4'd9: r = POW_W'(1000000000);
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

FILE: design/itda_front.sv
// Front end: takes the signed value, forms sign, magnitude and digit count.
// Depends on itda_pkg.
`timescale 1ns / 1ps
module itda_front (
	input  logic signed [itda_pkg::VALUE_W-1:0] value,
	output itda_pkg::item_t                     item
);
	logic [itda_pkg::VALUE_W-1:0] raw;
	logic [itda_pkg::VALUE_W-1:0] mag;
	logic [itda_pkg::NDIG_W-1:0]  ndig;

	assign raw = itda_pkg::VALUE_W'(value);
	assign mag = raw[itda_pkg::VALUE_W-1] ? (itda_pkg::VALUE_W'(0) - raw) : raw;

	always_comb begin
		ndig = itda_pkg::NDIG_W'(1);
		for (int i = 1; i < itda_pkg::MAX_DIGITS; i++) begin
			if ({{(itda_pkg::POW_W-itda_pkg::VALUE_W){1'b0}}, mag} >=
			    itda_pkg::pow10(itda_pkg::NDIG_W'(i))) begin
				ndig = itda_pkg::NDIG_W'(i + 1);
			end
		end
	end

	assign item.neg  = raw[itda_pkg::VALUE_W-1];
	assign item.mag  = mag;
	assign item.ndig = ndig;
endmodule

FILE: design/itda_queue.sv
// Short queue of classified items between the front end and the digit engine.
// Depends on itda_pkg.
`timescale 1ns / 1ps
module itda_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  itda_pkg::item_t wr_item,
	output logic            full,
	input  logic            rd_en,
	output itda_pkg::item_t rd_item,
	output logic            not_empty
);
	itda_pkg::item_t                mem_q [itda_pkg::QUEUE_DEPTH];
	logic [itda_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [itda_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [itda_pkg::QCNT_W-1:0]    count_q;
	logic                           do_wr;
	logic                           do_rd;

	assign full      = (count_q == itda_pkg::QCNT_W'(itda_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == itda_pkg::QPTR_W'(itda_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : wr_ptr_q + itda_pkg::QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == itda_pkg::QPTR_W'(itda_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : rd_ptr_q + itda_pkg::QPTR_W'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + itda_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - itda_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

FILE: design/itda_back.sv
// Digit engine: emits sign and digits most significant first, one per cycle
// unless the receiver stalls, through an output register. Depends on itda_pkg.
`timescale 1ns / 1ps
module itda_back (
	input  logic            clk,
	input  logic            arst_n,
	input  itda_pkg::item_t item,
	input  logic            item_valid,
	output logic            item_take,
	output logic            empty,
	input  logic            pop,
	output logic [7:0]      char_code,
	output logic            is_last,
	output logic [3:0]      text_length
);
	itda_pkg::back_state_t          state_q;
	logic [itda_pkg::VALUE_W-1:0]   rem_q;
	logic [itda_pkg::NDIG_W-1:0]    pos_q;
	logic [3:0]                     len_q;
	logic                           out_valid_q;
	logic [7:0]                     char_q;
	logic                           last_q;
	logic [3:0]                     out_len_q;
	logic                           adv;
	logic [itda_pkg::DIFF_W-1:0]    diff [itda_pkg::DIGIT_MAX:1];
	logic [3:0]                     digit;
	logic [itda_pkg::VALUE_W-1:0]   rem_next;

	assign adv       = !out_valid_q || pop;
	assign item_take = (state_q == itda_pkg::ST_IDLE) && item_valid;

	always_comb begin
		digit    = '0;
		rem_next = rem_q;
		for (int j = 1; j <= itda_pkg::DIGIT_MAX; j++) begin
			diff[j] = {{(itda_pkg::DIFF_W-itda_pkg::VALUE_W){1'b0}}, rem_q} -
			          {1'b0, itda_pkg::pow10(pos_q) * itda_pkg::POW_W'(j)};
			if (!diff[j][itda_pkg::DIFF_W-1]) begin
				digit    = 4'(j);
				rem_next = diff[j][itda_pkg::VALUE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			rem_q <= item.mag;
			pos_q <= item.ndig - itda_pkg::NDIG_W'(1);
			len_q <= 4'(item.ndig) + {3'b000, item.neg};
		end else if (state_q == itda_pkg::ST_DIGIT && adv) begin
			rem_q <= rem_next;
			pos_q <= pos_q - itda_pkg::NDIG_W'(1);
		end
		if (adv && state_q == itda_pkg::ST_SIGN) begin
			char_q    <= itda_pkg::CHAR_MINUS;
			last_q    <= 1'b0;
			out_len_q <= len_q;
		end else if (adv && state_q == itda_pkg::ST_DIGIT) begin
			char_q    <= itda_pkg::CHAR_ZERO + {4'b0000, digit};
			last_q    <= (pos_q == '0);
			out_len_q <= len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itda_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				itda_pkg::ST_IDLE: begin
					if (pop) begin
						out_valid_q <= 1'b0;
					end
					if (item_take) begin
						state_q <= item.neg ? itda_pkg::ST_SIGN : itda_pkg::ST_DIGIT;
					end
				end
				itda_pkg::ST_SIGN: begin
					if (adv) begin
						out_valid_q <= 1'b1;
						state_q     <= itda_pkg::ST_DIGIT;
					end
				end
				itda_pkg::ST_DIGIT: begin
					if (adv) begin
						out_valid_q <= 1'b1;
						if (pos_q == '0) begin
							state_q <= itda_pkg::ST_IDLE;
						end
					end
				end
				default: begin
					state_q     <= itda_pkg::ST_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign empty       = !out_valid_q;
	assign char_code   = char_q;
	assign is_last     = last_q;
	assign text_length = out_len_q;
endmodule

FILE: design/int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII text converter.
// Depends on itda_pkg, itda_front, itda_queue, itda_back and assert_macros.svh.
//
// Usage:
//   Input side is a queue write port: drive value and raise push; a transfer
//   happens on a rising edge with push high and full low.
//   Result side is a queue read port: while empty is low, char_code, is_last
//   and text_length show the oldest character; a transfer happens on a rising
//   edge with pop high and empty low.
//   Each value yields a run of 1 to 11 characters: an optional '-', then the
//   digits most significant first. is_last marks the final character and
//   text_length carries the run length on every character.
//   The front end classifies a value in the cycle of its transfer and parks it
//   in a two-entry queue. The digit engine loads an item in its idle state,
//   then forms one character per step while the receiver keeps up; a value
//   passes the queue, the engine load and the output register before its first
//   character shows. Each digit comes from one compare-and-subtract step
//   against the power-of-ten table.
//   When the receiver stalls, the output register holds its character, the
//   engine waits, and full rises once the queue holds two items.
//   Reset empties the queue, idles the engine and clears the output valid flag.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module int_to_decimal_ascii (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [itda_pkg::VALUE_W-1:0] value,
	output logic                                empty,
	input  logic                                pop,
	output logic [7:0]                          char_code,
	output logic                                is_last,
	output logic [3:0]                          text_length
);
	itda_pkg::item_t front_item;
	itda_pkg::item_t head_item;
	logic            head_valid;
	logic            head_take;
	logic            is_minus;
	logic            char_ok;
	logic            len_ok;

	itda_front u_front (
		.value (value),
		.item  (front_item)
	);

	itda_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (push),
		.wr_item   (front_item),
		.full      (full),
		.rd_en     (head_take),
		.rd_item   (head_item),
		.not_empty (head_valid)
	);

	itda_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (head_item),
		.item_valid  (head_valid),
		.item_take   (head_take),
		.empty       (empty),
		.pop         (pop),
		.char_code   (char_code),
		.is_last     (is_last),
		.text_length (text_length)
	);

	assign is_minus = (char_code == itda_pkg::CHAR_MINUS);
	assign char_ok  = is_minus ||
	                  ((char_code >= itda_pkg::CHAR_ZERO) && (char_code <= itda_pkg::CHAR_NINE));
	assign len_ok   = (text_length >= 4'd1) && (text_length <= 4'd11);

	`ASSERT_IMPLIES(a_char_legal, clk, arst_n, !empty, char_ok)
	`ASSERT_IMPLIES(a_len_range, clk, arst_n, !empty, len_ok)
	`ASSERT_IMPLIES(a_minus_not_last, clk, arst_n, !empty && is_minus, !is_last)
	`ASSERT_NEXT(a_run_continues, clk, arst_n, !empty && pop && !is_last, !empty)
endmodule
